/* rtl/kwm_pkg.sv */
// Package for the k-way merge heap: payload structs, state enum, register constants.
// Used by k_way_merge_heap and the testbench; depends on nothing.
`default_nettype none
package kwm_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned IndexWidth = 4;
  localparam int unsigned CountWidth = 5;
  localparam logic [CountWidth-1:0] ListCountReset = 5'd16;

  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic [IndexWidth-1:0]        list_index;
    logic                         has_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0] min_value;
    logic [IndexWidth-1:0]        source_list;
    logic                         last;
  } out_beat_t;

  typedef enum logic [2:0] {
    StIdle,
    StUpCmp,
    StUpPlace,
    StDecide,
    StPopWait,
    StDnCmp,
    StDnPlace
  } state_e;

endpackage
`default_nettype wire

/* rtl/kwm_ram.sv */
// Generic single-port-write, dual-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none
module kwm_ram #(
  parameter int unsigned Width = 36,
  parameter int unsigned Depth = 16
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(Depth)-1:0]  waddr_i,
  input  wire [Width-1:0]          wdata_i,
  input  wire [$clog2(Depth)-1:0]  raddr_a_i,
  input  wire [$clog2(Depth)-1:0]  raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // write one entry, read two; read data is registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule
`default_nettype wire

/* rtl/k_way_merge_heap.sv */
// k-way merge top level: binary min heap of list heads held in one RAM (kwm_ram).
// Depends on kwm_pkg and kwm_ram.
// Operation: a push climbs one heap level per cycle in StUpCmp (StUpPlace places it at the root);
// StDecide then reads the root, and while a merge runs StPopWait emits it and raises the strobe.
// A pop sinks one level per cycle in StDnCmp, plus a final placement in StDnPlace; busy holds
// until the block is back in StIdle, and a new item is accepted only while it is idle.
// The receiver cannot stall. Reset clears control state and sets list_count to 16; the heap
// RAM is not cleared.
`default_nettype none
module k_way_merge_heap #(
  parameter int unsigned MAX_LISTS = 16
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start,
  output logic                          busy,
  input  wire kwm_pkg::in_beat_t        in_i,
  output logic                          strobe,
  output kwm_pkg::out_beat_t            out_o,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire [kwm_pkg::CountWidth-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_LISTS);
  localparam int unsigned OW = AW + 1;
  localparam int unsigned CW = OW + 1;
  localparam int unsigned EW = kwm_pkg::ValueWidth + kwm_pkg::IndexWidth;

  kwm_pkg::state_e state_q, state_d;
  logic [OW-1:0] occ_q, occ_d;
  logic [OW-1:0] loaded_q, loaded_d;
  logic          merging_q, merging_d;
  logic [kwm_pkg::CountWidth-1:0] count_q;
  logic [AW-1:0] pos_q, pos_d;
  logic [EW-1:0] cur_q, cur_d;
  logic          strobe_q, strobe_d;
  kwm_pkg::out_beat_t out_q, out_d;

  // ram ports
  logic          we;
  logic [AW-1:0] waddr, ra, rb;
  logic [EW-1:0] wdata, rda, rdb;

  kwm_ram #(.Width(EW), .Depth(MAX_LISTS)) u_ram (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_a_i(ra), .raddr_b_i(rb), .rdata_a_o(rda), .rdata_b_o(rdb)
  );

  // key order: signed value, then list index
  function automatic logic ent_before(logic [EW-1:0] a, logic [EW-1:0] b);
    logic signed [kwm_pkg::ValueWidth-1:0] va, vb;
    va = a[EW-1:kwm_pkg::IndexWidth];
    vb = b[EW-1:kwm_pkg::IndexWidth];
    if (va != vb) return va < vb;
    return a[kwm_pkg::IndexWidth-1:0] < b[kwm_pkg::IndexWidth-1:0];
  endfunction

  function automatic logic [AW-1:0] parent_of(logic [AW-1:0] p);
    return (p - AW'(1)) >> 1;
  endfunction

  // effective list count, clamped to 1..MAX_LISTS
  logic [OW-1:0] eff_cnt;
  always_comb begin
    if (count_q == '0) eff_cnt = OW'(1);
    else if (32'(count_q) > MAX_LISTS) eff_cnt = OW'(MAX_LISTS);
    else eff_cnt = OW'(count_q);
  end

  // parent of the hole, children of the hole and of the smaller child
  logic [AW-1:0] parent;
  logic [OW-1:0] occ_m1;
  logic [CW-1:0] occ_ext, lch, rch, nlch, nrch;
  logic          take_r;
  logic [AW-1:0] child;
  logic [EW-1:0] child_ent;
  assign parent    = parent_of(pos_q);
  assign occ_m1    = occ_q - OW'(1);
  assign occ_ext   = {1'b0, occ_q};
  assign lch       = {1'b0, pos_q, 1'b1};
  assign rch       = lch + CW'(1);
  assign take_r    = (rch < occ_ext) && ent_before(rdb, rda);
  assign child     = take_r ? rch[AW-1:0] : lch[AW-1:0];
  assign child_ent = take_r ? rdb : rda;
  assign nlch      = {1'b0, child, 1'b1};
  assign nrch      = nlch + CW'(1);

  assign busy        = (state_q != kwm_pkg::StIdle);
  assign cfg_ready_o = !busy;
  assign strobe      = strobe_q;
  assign out_o       = out_q;

  // register list_count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= kwm_pkg::ListCountReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= kwm_pkg::StIdle;
      occ_q     <= '0;
      loaded_q  <= '0;
      merging_q <= 1'b0;
      strobe_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      occ_q     <= occ_d;
      loaded_q  <= loaded_d;
      merging_q <= merging_d;
      strobe_q  <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    cur_q <= cur_d;
    out_q <= out_d;
  end

  // sequencer: sift up after a push, then decide, then (while merging) pop and sift down
  always_comb begin
    state_d   = state_q;
    occ_d     = occ_q;
    loaded_d  = loaded_q;
    merging_d = merging_q;
    pos_d     = pos_q;
    cur_d     = cur_q;
    out_d     = out_q;
    strobe_d  = 1'b0;
    we        = 1'b0;
    waddr     = pos_q;
    wdata     = cur_q;
    ra        = parent;
    rb        = '0;
    unique case (state_q)
      kwm_pkg::StIdle: begin
        if (start) begin
          cur_d = {in_i.value, in_i.list_index};
          if (in_i.has_value && occ_q < OW'(MAX_LISTS)) begin
            // open a hole at the tail; read its parent, or write the root if the heap is empty
            occ_d = occ_q + OW'(1);
            pos_d = occ_q[AW-1:0];
            if (occ_q == '0) begin
              we      = 1'b1;
              waddr   = '0;
              wdata   = {in_i.value, in_i.list_index};
              state_d = kwm_pkg::StDecide;
            end else begin
              ra      = parent_of(occ_q[AW-1:0]);
              state_d = kwm_pkg::StUpCmp;
            end
          end else begin
            state_d = kwm_pkg::StDecide;
          end
        end
      end
      kwm_pkg::StUpCmp: begin
        // rda holds the parent of the hole: move it down or settle here
        we = 1'b1;
        if (ent_before(cur_q, rda)) begin
          wdata = rda;
          pos_d = parent;
          if (parent == '0) begin
            state_d = kwm_pkg::StUpPlace;
          end else begin
            ra = parent_of(parent);
          end
        end else begin
          state_d = kwm_pkg::StDecide;
        end
      end
      kwm_pkg::StUpPlace: begin
        we      = 1'b1;
        state_d = kwm_pkg::StDecide;
      end
      kwm_pkg::StDecide: begin
        state_d = kwm_pkg::StIdle;
        ra      = '0;
        rb      = occ_m1[AW-1:0];
        if (!merging_q) begin
          if (loaded_q + OW'(1) < eff_cnt) begin
            loaded_d = loaded_q + OW'(1);
          end else begin
            loaded_d = '0;
            if (occ_q != '0) begin
              merging_d = 1'b1;
              state_d   = kwm_pkg::StPopWait;
            end
          end
        end else if (occ_q == '0) begin
          merging_d = 1'b0;
          loaded_d  = '0;
        end else begin
          state_d = kwm_pkg::StPopWait;
        end
      end
      kwm_pkg::StPopWait: begin
        // emit root, sink the tail entry from the root
        out_d.min_value   = rda[EW-1:kwm_pkg::IndexWidth];
        out_d.source_list = rda[kwm_pkg::IndexWidth-1:0];
        out_d.last        = (occ_q == OW'(1));
        strobe_d = 1'b1;
        occ_d    = occ_m1;
        if (occ_q == OW'(1)) begin
          merging_d = 1'b0;
          loaded_d  = '0;
          state_d   = kwm_pkg::StIdle;
        end else begin
          cur_d = rdb;
          pos_d = '0;
          if (occ_m1 == OW'(1)) begin
            we      = 1'b1;
            waddr   = '0;
            wdata   = rdb;
            state_d = kwm_pkg::StIdle;
          end else begin
            ra      = AW'(1);
            rb      = (occ_m1 > OW'(2)) ? AW'(2) : AW'(1);
            state_d = kwm_pkg::StDnCmp;
          end
        end
      end
      kwm_pkg::StDnCmp: begin
        // pick smaller child and move it up if it beats the sinking entry
        we = 1'b1;
        if (ent_before(child_ent, cur_q)) begin
          wdata = child_ent;
          pos_d = child;
          if (nlch < occ_ext) begin
            ra = nlch[AW-1:0];
            rb = (nrch < occ_ext) ? nrch[AW-1:0] : nlch[AW-1:0];
          end else begin
            state_d = kwm_pkg::StDnPlace;
          end
        end else begin
          state_d = kwm_pkg::StIdle;
        end
      end
      kwm_pkg::StDnPlace: begin
        we      = 1'b1;
        state_d = kwm_pkg::StIdle;
      end
      default: state_d = kwm_pkg::StIdle;
    endcase
  end

endmodule
`default_nettype wire

/* tb/tb.sv */
// Testbench for k_way_merge_heap: drives batches of sorted lists, predicts the merged
// stream with a behavioural min heap of list heads, and checks every emitted beat.
// Depends on kwm_pkg and the k_way_merge_heap RTL.
`default_nettype none
module tb;

  localparam int unsigned NumLists = 16;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned WatchdogLimit = 20000;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  kwm_pkg::in_beat_t in_i;
  logic strobe;
  kwm_pkg::out_beat_t out_o;
  logic cfg_valid;
  logic cfg_ready;
  logic [kwm_pkg::CountWidth-1:0] cfg_data;

  k_way_merge_heap #(.MAX_LISTS(NumLists)) i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .in_i(in_i),
    .strobe(strobe), .out_o(out_o), .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_data_i(cfg_data)
  );

  // Predictor state: heap of list heads, batch progress and the list count
  logic signed [kwm_pkg::ValueWidth-1:0] heap_val[NumLists];
  logic [kwm_pkg::IndexWidth-1:0] heap_src[NumLists];
  int unsigned heap_fill;
  int unsigned heads_seen;
  bit in_merge;
  logic [kwm_pkg::CountWidth-1:0] lists_reg;
  kwm_pkg::out_beat_t merged_q[$];

  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned burst_left;

  // Sender shadow of the merge: list contents still to send, and last emitted list
  logic signed [kwm_pkg::ValueWidth-1:0] next_head;
  int unsigned lists_todo[NumLists];
  logic signed [kwm_pkg::ValueWidth-1:0] list_cur[NumLists];
  logic [kwm_pkg::IndexWidth-1:0] refill_list;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit pops_first(int unsigned a, int unsigned b);
    if (heap_val[a] != heap_val[b]) return heap_val[a] < heap_val[b];
    return heap_src[a] < heap_src[b];
  endfunction

  function automatic void swap_heap(int unsigned a, int unsigned b);
    logic signed [kwm_pkg::ValueWidth-1:0] v;
    logic [kwm_pkg::IndexWidth-1:0] s;
    v = heap_val[a]; s = heap_src[a];
    heap_val[a] = heap_val[b]; heap_src[a] = heap_src[b];
    heap_val[b] = v; heap_src[b] = s;
  endfunction

  function automatic void heap_insert(logic signed [kwm_pkg::ValueWidth-1:0] v,
                                      logic [kwm_pkg::IndexWidth-1:0] s);
    int unsigned i;
    if (heap_fill >= NumLists) return;  // drop a push into a full heap
    i = heap_fill++;
    heap_val[i] = v; heap_src[i] = s;
    while (i > 0 && pops_first(i, (i - 1) / 2)) begin
      swap_heap(i, (i - 1) / 2);
      i = (i - 1) / 2;
    end
  endfunction

  function automatic kwm_pkg::out_beat_t heap_take_min();
    kwm_pkg::out_beat_t r;
    int unsigned i, l, m;
    i = 0;
    r.min_value = heap_val[0];
    r.source_list = heap_src[0];
    heap_fill--;
    r.last = (heap_fill == 0);
    if (heap_fill == 0) return r;
    heap_val[0] = heap_val[heap_fill]; heap_src[0] = heap_src[heap_fill];
    forever begin
      l = 2 * i + 1; m = i;
      if (l < heap_fill && pops_first(l, m)) m = l;
      if (l + 1 < heap_fill && pops_first(l + 1, m)) m = l + 1;
      if (m == i) break;
      swap_heap(i, m);
      i = m;
    end
    return r;
  endfunction

  function automatic int unsigned batch_size();
    if (lists_reg == 0) return 1;
    if (lists_reg > NumLists) return NumLists;
    return lists_reg;
  endfunction

  // Work out the beat, if any, that one accepted item causes
  function automatic void predict_merge(kwm_pkg::in_beat_t b);
    kwm_pkg::out_beat_t r;
    if (b.has_value) heap_insert(b.value, b.list_index);
    if (!in_merge) begin
      heads_seen++;
      if (heads_seen < batch_size()) return;
      heads_seen = 0;
      if (heap_fill == 0) return;
      in_merge = 1'b1;
    end else if (heap_fill == 0) begin
      in_merge = 1'b0;
      heads_seen = 0;
      return;
    end
    r = heap_take_min();
    merged_q.push_back(r);
    refill_list = r.source_list;
    if (r.last) begin
      in_merge = 1'b0;
      heads_seen = 0;
    end
  endfunction

  // Check each emitted beat against the oldest prediction; count idle cycles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || (cfg_valid && cfg_ready) || strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (strobe) begin
        if (merged_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat %p", out_o);
        end else if (merged_q[0] !== out_o) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", merged_q[0], out_o);
          void'(merged_q.pop_front());
        end else begin
          void'(merged_q.pop_front());
        end
      end
    end
  end

  // Abort on a stalled run
  initial begin
    wait (rst_ni);
    wait (idle_cycles >= WatchdogLimit);
    $display("k_way_merge_heap test failed");
    $finish;
  end

  // Drop start and put noise on the payload
  task automatic idle_bus();
    start <= 1'b0;
    in_i <= {$urandom(), 5'($urandom())};
  endtask

  // Send one item; items come in bursts of random length with random gaps between
  task automatic send_item(logic signed [kwm_pkg::ValueWidth-1:0] v,
                           logic [kwm_pkg::IndexWidth-1:0] idx, bit has);
    kwm_pkg::in_beat_t b;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        idle_bus();
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
    end
    burst_left--;
    b.value = v; b.list_index = idx; b.has_value = has;
    start <= 1'b1;
    in_i <= b;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_merge(b);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    idle_bus();
    while (merged_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_list_count(logic [kwm_pkg::CountWidth-1:0] n);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= n;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    lists_reg = n;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Run one well-formed batch: lists of random length merged through the block
  task automatic run_batch(int unsigned max_len, bit narrow, output int unsigned count);
    int unsigned n, k, sent;
    n = batch_size();
    for (k = 0; k < n; k++) begin
      lists_todo[k] = $urandom_range(0, max_len);
      list_cur[k] = narrow ? $signed($urandom_range(0, 20)) - 10 : $signed($urandom());
      if (!narrow && list_cur[k] > 32'sh7000_0000) list_cur[k] = list_cur[k] - 32'sh1000_0000;
    end
    for (k = 0; k < n; k++) begin
      if (lists_todo[k] != 0) lists_todo[k]--;
      send_item(list_cur[k], k[kwm_pkg::IndexWidth-1:0],
                lists_todo[k] != 0 || $urandom_range(0, 1));
    end
    sent = 0;
    while (in_merge && sent < 400) begin
      k = refill_list;
      if (k < n && lists_todo[k] != 0) begin
        lists_todo[k]--;
        next_head = list_cur[k] + (narrow ? $urandom_range(0, 2) : $urandom_range(0, 1000));
        if (next_head < list_cur[k]) next_head = list_cur[k];
        list_cur[k] = next_head;
        send_item(list_cur[k], k[kwm_pkg::IndexWidth-1:0], 1'b1);
      end else begin
        send_item($signed($urandom()), k[kwm_pkg::IndexWidth-1:0], 1'b0);
      end
      sent++;
    end
    count = n + sent;
  endtask

  // Field extremes, all-empty batch, ties and a single list
  task automatic test_directed();
    int unsigned batch_items;
    write_list_count(5'd3);
    send_item(32'sh8000_0000, 4'd15, 1'b1);
    send_item(32'sh7fff_ffff, 4'd0, 1'b1);
    send_item(32'sh8000_0000, 4'd1, 1'b1);
    send_item(32'sh0, 4'd1, 1'b0);
    send_item(32'sh0, 4'd15, 1'b0);
    // all lists empty: no beat, stay in load
    send_item(32'sh1234, 4'd0, 1'b0);
    send_item(32'sh1234, 4'd1, 1'b0);
    send_item(32'sh1234, 4'd2, 1'b0);
    write_list_count(5'd0);
    send_item(-32'sd1, 4'd7, 1'b1);
    send_item(32'sd5, 4'd7, 1'b1);
    send_item(32'sd0, 4'd7, 1'b0);
    write_list_count(5'd31);
    run_batch(2, 1'b1, batch_items);
  endtask

  // Full heap: sixteen heads, then two refills and empty refills that drain it
  task automatic test_overflow();
    int unsigned k;
    write_list_count(5'd16);
    for (k = 0; k < 16; k++) send_item($signed($urandom()), k[kwm_pkg::IndexWidth-1:0], 1'b1);
    send_item(32'sd3, 4'd2, 1'b1);
    send_item(32'sd4, 4'd2, 1'b1);
    while (in_merge) send_item(32'sd0, refill_list, 1'b0);
  endtask

  // Random batches over several list counts, with noise items mixed in
  task automatic test_random();
    int unsigned items, batch_items;
    items = 0;
    while (items < 1850) begin
      if ($urandom_range(0, 7) == 0) begin
        wait_drained();
        write_list_count($urandom_range(0, 4) == 0 ? 5'($urandom()) : 5'($urandom_range(1, 16)));
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 20)) begin
          send_item($signed($urandom()), 4'($urandom()), 1'($urandom()));
          items++;
        end
        // finish whatever merge the noise began
        while (in_merge) begin
          send_item(32'sh0, refill_list, 1'b0);
          items++;
        end
      end else begin
        run_batch($urandom_range(0, 3) == 0 ? 12 : 4, $urandom_range(0, 1), batch_items);
        items += batch_items;
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    in_i = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    heap_fill = 0;
    heads_seen = 0;
    in_merge = 1'b0;
    lists_reg = kwm_pkg::ListCountReset;
    mismatches = 0;
    idle_cycles = 0;
    burst_left = 0;
    refill_list = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_overflow();
    test_random();
    wait_drained();
    if (mismatches == 0 && merged_q.size() == 0) begin
      $display("k_way_merge_heap test passed");
    end else begin
      $display("k_way_merge_heap test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* k_way_merge_heap.f */
rtl/kwm_pkg.sv
rtl/kwm_ram.sv
rtl/k_way_merge_heap.sv
tb/tb.sv
